// ----- src/rvc_pkg.sv -----
// Package for the repeated value collector.
// Holds field widths, the action codes, the mark encoding and the control states.
// No dependencies.
`timescale 1ns / 1ps

package rvc_pkg;

  // Field widths
  localparam int VALUE_W   = 10;
  localparam int ACTION_W  = 2;
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 16;
  localparam int M_TUSER_W = 2;

  // Input action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD   = 2'd0,
    ACT_FETCH = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  // Per-value mark held in the store
  typedef enum logic [1:0] {
    MARK_UNSEEN   = 2'd0,
    MARK_ONCE     = 2'd1,
    MARK_REPEATED = 2'd2
  } mark_t;

  // Control states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CLEAR
  } state_t;

endpackage

// ----- src/rvc_mark_ram.sv -----
// Mark store of the repeated value collector: one write port, one read port,
// read data registered (read-first on a same-address collision). Uses rvc_pkg.
`timescale 1ns / 1ps

module rvc_mark_ram
  import rvc_pkg::*;
#(
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  mark_t             wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output mark_t             rd_data
);

  mark_t mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one entry, data valid next cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/repeated_value_collect_core.sv -----
// Top level of the repeated value collector: control, add pipeline, scan and
// clearing sweep around the mark store. Uses rvc_pkg and rvc_mark_ram.
//
//   Channel   Dir  Handshake          Payload
//   s_*       in   s_tvalid/s_tready  s_tuser = action, s_tdata = value
//   m_*       out  m_tvalid/m_tready  m_tdata = dup_value, m_tuser = {scan_done, dup_valid}
//
// Add items are taken one per cycle while idle; each is a registered read-modify-write
// of the mark store, with the store write forwarded to a same-value read.
// A fetch scans the store from the cursor until it finds a repeated value or the end,
// one store read per cycle. A clear sweeps every entry of the store back to unseen, and
// after reset the same sweep runs before s_tready rises.
// A fetch result waits in the output register; a new fetch holds its answer
// until that register is free.
`timescale 1ns / 1ps

module repeated_value_collect_core
  import rvc_pkg::*;
#(
  parameter int VALUE_COUNT = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [9:0] value
  input  logic [ACTION_W-1:0]  s_tuser,   // [1:0] action
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [9:0] dup_value
  output logic [M_TUSER_W-1:0] m_tuser    // [0] dup_valid, [1] scan_done
);

  localparam int IDX_W  = $clog2(VALUE_COUNT);
  localparam int CUR_W  = $clog2(VALUE_COUNT + 1);
  localparam int WIDE_W = (CUR_W > VALUE_W) ? CUR_W : VALUE_W;
  localparam logic [CUR_W-1:0] CUR_END  = CUR_W'(VALUE_COUNT);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(VALUE_COUNT - 1);

  // Control and scan state
  state_t            state, state_next;
  logic [CUR_W-1:0]  cursor, cursor_next;
  logic [CUR_W-1:0]  issue_pos, issue_pos_next;
  logic [CUR_W-1:0]  check_pos, check_pos_next;
  logic              chk_valid, chk_valid_next;
  logic [IDX_W-1:0]  clr_idx, clr_idx_next;

  // Add stage
  logic              add_valid;
  logic [IDX_W-1:0]  add_idx;
  logic              add_fwd;
  mark_t             add_fwd_mark;
  mark_t             add_old;
  mark_t             add_new;

  // Output register
  logic              out_valid, out_valid_next;
  logic [VALUE_W-1:0] out_value, out_value_next;
  logic              out_dup, out_dup_next;
  logic              out_done, out_done_next;

  // Store ports
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  mark_t             wr_data;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  mark_t             rd_data;

  // Input decode
  action_t           in_action;
  logic [WIDE_W-1:0] in_wide;
  logic              in_range;
  logic [IDX_W-1:0]  in_idx;
  logic              in_add;
  logic              slot_free;
  logic              found;

  assign in_action = action_t'(s_tuser);
  assign in_wide   = WIDE_W'(s_tdata[VALUE_W-1:0]);
  assign in_range  = in_wide < WIDE_W'(VALUE_COUNT);
  assign in_idx    = IDX_W'(in_wide);
  assign in_add    = s_tvalid && s_tready && (in_action == ACT_ADD) && in_range;

  assign slot_free = !out_valid || m_tready;
  assign found     = chk_valid && (rd_data == MARK_REPEATED);

  // Update the mark of the value in the add stage
  assign add_old = add_fwd ? add_fwd_mark : rd_data;
  assign add_new = (add_old == MARK_UNSEEN) ? MARK_ONCE : MARK_REPEATED;

  rvc_mark_ram #(
    .DEPTH (VALUE_COUNT)
  ) u_mark_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Next state, store access and result
  always_comb begin
    state_next     = state;
    cursor_next    = cursor;
    issue_pos_next = issue_pos;
    check_pos_next = check_pos;
    chk_valid_next = chk_valid;
    clr_idx_next   = clr_idx;
    out_valid_next = out_valid && !m_tready;
    out_value_next = out_value;
    out_dup_next   = out_dup;
    out_done_next  = out_done;
    s_tready       = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = in_idx;
    wr_en          = add_valid;
    wr_addr        = add_idx;
    wr_data        = add_new;

    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (in_action)
            ACT_ADD: begin
              rd_en = in_range;
            end
            ACT_FETCH: begin
              state_next     = ST_SCAN;
              issue_pos_next = cursor;
              chk_valid_next = 1'b0;
            end
            ACT_CLEAR: begin
              state_next   = ST_CLEAR;
              clr_idx_next = '0;
              cursor_next  = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (found) begin
          // Report the repeated value once the output slot is free
          if (slot_free) begin
            out_valid_next = 1'b1;
            out_value_next = VALUE_W'(check_pos);
            out_dup_next   = 1'b1;
            out_done_next  = 1'b0;
            cursor_next    = CUR_W'(check_pos + 1'b1);
            chk_valid_next = 1'b0;
            state_next     = ST_IDLE;
          end
        end else if (issue_pos < CUR_END) begin
          // Advance the scan by one entry
          rd_en          = 1'b1;
          rd_addr        = IDX_W'(issue_pos);
          check_pos_next = issue_pos;
          chk_valid_next = 1'b1;
          issue_pos_next = CUR_W'(issue_pos + 1'b1);
        end else if (slot_free) begin
          // Nothing left: report done and park the cursor at the end
          out_valid_next = 1'b1;
          out_value_next = '0;
          out_dup_next   = 1'b0;
          out_done_next  = 1'b1;
          cursor_next    = CUR_END;
          chk_valid_next = 1'b0;
          state_next     = ST_IDLE;
        end
      end

      ST_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_idx;
        wr_data      = MARK_UNSEEN;
        clr_idx_next = IDX_W'(clr_idx + 1'b1);
        if (clr_idx == IDX_LAST) begin
          state_next  = ST_IDLE;
          cursor_next = '0;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers; reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cursor    <= '0;
      chk_valid <= 1'b0;
      clr_idx   <= '0;
      add_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cursor    <= cursor_next;
      chk_valid <= chk_valid_next;
      clr_idx   <= clr_idx_next;
      add_valid <= in_add;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers; capture the write that collides with this read
  always_ff @(posedge clk) begin
    issue_pos    <= issue_pos_next;
    check_pos    <= check_pos_next;
    add_idx      <= in_idx;
    add_fwd      <= rd_en && wr_en && (wr_addr == rd_addr);
    add_fwd_mark <= wr_data;
    out_value    <= out_value_next;
    out_dup      <= out_dup_next;
    out_done     <= out_done_next;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = M_TDATA_W'(out_value);
  assign m_tuser  = {out_done, out_dup};

  // An add write never overlaps the clearing sweep or a scan
  assert property (@(posedge clk) disable iff (rst) add_valid |-> state == ST_IDLE)
    else $error("add write outside idle state");

  // The cursor never passes the end of the store
  assert property (@(posedge clk) disable iff (rst) cursor <= CUR_END)
    else $error("scan cursor beyond store end");

  // Checked scan data always belongs to an entry inside the store
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && chk_valid) |-> check_pos < CUR_END)
    else $error("scan checks an entry outside the store");

  // A result is never both a repeated value and a finished scan
  assert property (@(posedge clk) disable iff (rst) out_valid |-> (out_dup != out_done))
    else $error("result flags inconsistent");

endmodule

// ----- tb/repeated_value_collect_core_test.sv -----
// Self-checking testbench for repeated_value_collect_core: random and directed add, fetch
// and clear transfers checked against an in-bench model of the mark store and scan cursor.
// Depends on rvc_pkg and the core; needs no files or arguments.
`timescale 1ns / 1ps

module repeated_value_collect_core_test;
  import rvc_pkg::*;

  localparam int VALUE_COUNT = 1024;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;  // undefined code, must be ignored
  localparam int HOLD_CYCLES = 3000;
  localparam int DRAIN_CYCLES = VALUE_COUNT + 80;
  localparam int PHASE_ITEMS = 400;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [VALUE_W-1:0]  val;
  } stream_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] dup_value;
    logic               dup_valid;
    logic               scan_done;
  } dup_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;   // [9:0] value
  logic [ACTION_W-1:0]  s_tuser = '0;   // [1:0] action
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;        // [9:0] dup_value
  logic [M_TUSER_W-1:0] m_tuser;        // [0] dup_valid, [1] scan_done

  stream_item_t pending_items[$];
  dup_result_t  expected_dups[$];
  int           items_queued = 0;
  int           send_idle_pct = 15;
  int           recv_idle_pct = 84;
  int           fail_count = 0;
  bit           hold_req = 1'b0;
  bit           hold_used = 1'b0;
  int           hold_left = 0;

  // Mirror of the mark store and cursor
  mark_t value_marks[VALUE_COUNT];
  int    scan_cursor;

  repeated_value_collect_core #(
    .VALUE_COUNT(VALUE_COUNT)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  function automatic void clear_marks();
    for (int i = 0; i < VALUE_COUNT; i++) value_marks[i] = MARK_UNSEEN;
    scan_cursor = 0;
  endfunction

  // Update the mirror for one accepted transfer and queue the fetch answer
  function automatic void track_transfer(stream_item_t it);
    int          pos;
    dup_result_t res;
    case (it.act)
      ACT_ADD: begin
        if (value_marks[it.val] == MARK_UNSEEN) value_marks[it.val] = MARK_ONCE;
        else value_marks[it.val] = MARK_REPEATED;
      end
      ACT_FETCH: begin
        pos = scan_cursor;
        while (pos < VALUE_COUNT && value_marks[pos] != MARK_REPEATED) pos++;
        if (pos < VALUE_COUNT) begin
          res = '{dup_value: pos[VALUE_W-1:0], dup_valid: 1'b1, scan_done: 1'b0};
          scan_cursor = pos + 1;
        end else begin
          res = '{dup_value: '0, dup_valid: 1'b0, scan_done: 1'b1};
          scan_cursor = VALUE_COUNT;
        end
        expected_dups.insert(expected_dups.size(), res);
      end
      ACT_CLEAR: clear_marks();
      default: ;
    endcase
  endfunction

  // Drive the input stream from the pending queue
  always @(posedge clk) begin : drive_input
    stream_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
      clear_marks();
    end else begin
      if (s_tvalid && s_tready) track_transfer('{act: s_tuser, val: s_tdata[VALUE_W-1:0]});
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          it = pending_items.pop_front();
          s_tdata  <= {{(S_TDATA_W-VALUE_W){1'b0}}, it.val};
          s_tuser  <= it.act;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Drive m_tready; one long hold lets the core back up into its input
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_used) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check each result transfer against the oldest expected answer
  always @(posedge clk) begin : check_output
    dup_result_t exp_dup;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_dups.size() == 0) begin
        $display("%0t: unexpected result value=%0d valid=%0b done=%0b", $time,
                 m_tdata[VALUE_W-1:0], m_tuser[0], m_tuser[1]);
        fail_count++;
      end else begin
        exp_dup = expected_dups.pop_front();
        if (m_tdata[VALUE_W-1:0] !== exp_dup.dup_value || m_tuser[0] !== exp_dup.dup_valid ||
            m_tuser[1] !== exp_dup.scan_done) begin
          $display("%0t: mismatch expected value=%0d valid=%0b done=%0b, got value=%0d valid=%0b done=%0b",
                   $time, exp_dup.dup_value, exp_dup.dup_valid, exp_dup.scan_done,
                   m_tdata[VALUE_W-1:0], m_tuser[0], m_tuser[1]);
          fail_count++;
        end
      end
    end
  end

  task automatic queue_op(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] val);
    stream_item_t item;
    item = '{act: act, val: val};
    pending_items.insert(pending_items.size(), item);
    items_queued++;
  endtask

  // Clear, then mixed items, mostly adds clustered in a window so values repeat, then mostly fetches
  task automatic queue_session();
    int width;
    int base;
    int r;
    width = ($urandom_range(7) == 0) ? VALUE_COUNT : $urandom_range(64, 4);
    base  = $urandom_range(VALUE_COUNT - width);
    queue_op(ACT_CLEAR, VALUE_W'($urandom));
    repeat ($urandom_range(60, 10)) begin
      r = $urandom_range(99);
      if (r < 8) queue_op(ACT_FETCH, VALUE_W'($urandom));
      else if (r < 11) queue_op(ACT_UNUSED, VALUE_W'($urandom));
      else if (r < 15) queue_op(ACT_ADD, VALUE_W'($urandom_range(VALUE_COUNT - 1)));
      else queue_op(ACT_ADD, VALUE_W'(base + $urandom_range(width - 1)));
    end
    repeat ($urandom_range(24, 2)) begin
      // adds here often land below the cursor
      if ($urandom_range(9) == 0) queue_op(ACT_ADD, VALUE_W'(base + $urandom_range(width - 1)));
      else queue_op(ACT_FETCH, VALUE_W'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || s_tvalid || expected_dups.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int target;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, third occurrence, unused action, add below cursor
    queue_op(ACT_ADD, 10'd0);
    queue_op(ACT_ADD, 10'd0);
    queue_op(ACT_ADD, 10'd1023);
    queue_op(ACT_ADD, 10'd1023);
    queue_op(ACT_ADD, 10'd1023);
    queue_op(ACT_ADD, 10'd341);
    queue_op(ACT_ADD, 10'd341);
    queue_op(ACT_ADD, 10'd682);
    queue_op(ACT_UNUSED, 10'd682);
    queue_op(ACT_FETCH, 10'd0);
    queue_op(ACT_FETCH, 10'd1023);
    queue_op(ACT_ADD, 10'd5);
    queue_op(ACT_ADD, 10'd5);
    queue_op(ACT_FETCH, 10'd0);
    queue_op(ACT_FETCH, 10'd0);
    queue_op(ACT_FETCH, 10'd0);
    queue_op(ACT_CLEAR, 10'd1023);
    queue_op(ACT_FETCH, 10'd0);
    queue_op(ACT_ADD, 10'd682);
    queue_op(ACT_ADD, 10'd682);
    queue_op(ACT_FETCH, 10'd0);
    queue_op(ACT_FETCH, 10'd0);
    queue_op(ACT_CLEAR, 10'd0);
    wait_drained();

    // Sender rarely idles, receiver mostly stalls; start the long hold here
    @(negedge clk);
    hold_req = 1'b1;
    target = items_queued + PHASE_ITEMS;
    while (items_queued < target) queue_session();
    wait_drained();

    // Swap the idle ratios
    send_idle_pct = 84;
    recv_idle_pct = 15;
    target = items_queued + PHASE_ITEMS;
    while (items_queued < target) queue_session();
    wait_drained();

    // Full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    target = items_queued + PHASE_ITEMS;
    while (items_queued < target) queue_session();
    wait_drained();

    // Let a late scan or sweep finish, catching any stray result
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && expected_dups.size() == 0) begin
      $display("[repeated_value_collect_core] OK");
    end else begin
      $display("[repeated_value_collect_core] ERROR");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("[repeated_value_collect_core] ERROR");
    $finish;
  end

endmodule
